// File: src/hrhp_pkg.sv
// shared types and constants for the http response header parser
package hrhp_pkg;

	// ascii characters the parser looks for
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// field name searched for, in byte order
	localparam int PATTERN_LEN = 16;
	localparam logic [7:0] LENGTH_PATTERN [PATTERN_LEN] = '{
		8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
		8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
	};

	// match index values: whole field name matched, and digit run has hit a non-digit
	localparam logic [4:0] MATCH_FULL  = 5'd16;
	localparam logic [4:0] CONV_ENDED  = 5'd17;

	// largest status value three digits can give
	localparam logic [9:0] STATUS_MAX = 10'd999;

	// header terminator progress
	typedef enum logic [2:0] {
		TERM_NONE    = 3'd0,
		TERM_CR      = 3'd1,
		TERM_CRLF    = 3'd2,
		TERM_CRLFCR  = 3'd3,
		TERM_LF      = 3'd4
	} term_state_t;

	// status code collection
	typedef enum logic [2:0] {
		STAT_WAIT_SPACE = 3'd0,
		STAT_DIGIT1     = 3'd1,
		STAT_DIGIT2     = 3'd2,
		STAT_DIGIT3     = 3'd3,
		STAT_DONE       = 3'd4
	} status_state_t;

	// one input beat held in the input register
	typedef struct packed {
		logic [7:0] rx_byte;
		logic       last_byte;
	} beat_t;

	// one result, body_offset in the lowest bits
	typedef struct packed {
		logic        length_found;
		logic [31:0] content_length;
		logic [9:0]  status_code;
		logic        header_complete;
		logic [11:0] body_offset;
	} result_t;

endpackage

// File: src/hrhp_in_stage.sv
// input register stage for received bytes
module hrhp_in_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	input  logic [7:0]     s_tdata,   // rx_byte
	input  logic           s_tlast,   // last_byte
	input  logic           advance,
	output logic           valid_s1,
	output hrhp_pkg::beat_t beat_s1
);

	// take a new beat when empty or when the held one moves on
	assign s_tready = !valid_s1 || advance;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			beat_s1.rx_byte   <= s_tdata;
			beat_s1.last_byte <= s_tlast;
		end
	end

endmodule

// File: src/hrhp_parse_core.sv
// parser state and per-byte update logic
module hrhp_parse_core #(
	parameter int BUFFER_BYTES = 2048
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  hrhp_pkg::beat_t   beat,
	output hrhp_pkg::result_t result
);

	localparam int OW = $clog2(BUFFER_BYTES + 1);
	localparam int BW = $clog2(BUFFER_BYTES + 2);
	localparam logic [OW-1:0] OFFSET_LIMIT = OW'(BUFFER_BYTES);

	logic [OW-1:0]           offset_q, offset_d;
	hrhp_pkg::term_state_t   term_q, term_d;
	logic [BW-1:0]           body_q, body_d;
	logic                    hdr_done_q, hdr_done_d;
	hrhp_pkg::status_state_t stat_q, stat_d;
	logic [9:0]              stat_acc_q, stat_acc_d;
	logic [4:0]              match_q, match_d;
	logic                    collecting_q, collecting_d;
	logic [31:0]             len_acc_q, len_acc_d;
	logic                    len_done_q, len_done_d;

	logic [7:0]  c;
	logic        is_digit;
	logic [3:0]  digit;
	logic [13:0] stat_mul;
	logic [35:0] len_mul;

	assign c        = beat.rx_byte;
	assign is_digit = (c >= hrhp_pkg::CHAR_ZERO) && (c <= hrhp_pkg::CHAR_NINE);
	assign digit    = 4'(c - hrhp_pkg::CHAR_ZERO);
	assign stat_mul = {1'b0, stat_acc_q, 3'b000} + {3'b000, stat_acc_q, 1'b0}
		+ {10'd0, digit};
	assign len_mul  = {1'b0, len_acc_q, 3'b000} + {3'b000, len_acc_q, 1'b0}
		+ {32'd0, digit};

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q     <= '0;
			term_q       <= hrhp_pkg::TERM_NONE;
			body_q       <= '0;
			hdr_done_q   <= 1'b0;
			stat_q       <= hrhp_pkg::STAT_WAIT_SPACE;
			stat_acc_q   <= '0;
			match_q      <= '0;
			collecting_q <= 1'b0;
			len_acc_q    <= '0;
			len_done_q   <= 1'b0;
		end else if (step) begin
			if (beat.last_byte) begin
				offset_q     <= '0;
				term_q       <= hrhp_pkg::TERM_NONE;
				body_q       <= '0;
				hdr_done_q   <= 1'b0;
				stat_q       <= hrhp_pkg::STAT_WAIT_SPACE;
				stat_acc_q   <= '0;
				match_q      <= '0;
				collecting_q <= 1'b0;
				len_acc_q    <= '0;
				len_done_q   <= 1'b0;
			end else begin
				offset_q     <= offset_d;
				term_q       <= term_d;
				body_q       <= body_d;
				hdr_done_q   <= hdr_done_d;
				stat_q       <= stat_d;
				stat_acc_q   <= stat_acc_d;
				match_q      <= match_d;
				collecting_q <= collecting_d;
				len_acc_q    <= len_acc_d;
				len_done_q   <= len_done_d;
			end
		end
	end

	// next state for one byte
	always_comb begin
		offset_d     = (offset_q < OFFSET_LIMIT) ? offset_q + 1'b1 : offset_q;
		term_d       = term_q;
		body_d       = body_q;
		hdr_done_d   = hdr_done_q;
		stat_d       = stat_q;
		stat_acc_d   = stat_acc_q;
		match_d      = match_q;
		collecting_d = collecting_q;
		len_acc_d    = len_acc_q;
		len_done_d   = len_done_q;

		// header terminator, first one wins
		if (!hdr_done_q) begin
			if (c == hrhp_pkg::CHAR_LF) begin
				if (term_q == hrhp_pkg::TERM_CRLF || term_q == hrhp_pkg::TERM_CRLFCR
						|| term_q == hrhp_pkg::TERM_LF) begin
					hdr_done_d = 1'b1;
					body_d     = BW'(offset_q) + 1'b1;
					term_d     = hrhp_pkg::TERM_NONE;
				end else if (term_q == hrhp_pkg::TERM_CR) begin
					term_d = hrhp_pkg::TERM_CRLF;
				end else begin
					term_d = hrhp_pkg::TERM_LF;
				end
			end else if (c == hrhp_pkg::CHAR_CR) begin
				term_d = (term_q == hrhp_pkg::TERM_CRLF) ? hrhp_pkg::TERM_CRLFCR
					: hrhp_pkg::TERM_CR;
			end else begin
				term_d = hrhp_pkg::TERM_NONE;
			end
		end

		// status code digits after the first space
		case (stat_q)
			hrhp_pkg::STAT_WAIT_SPACE: begin
				if (c == hrhp_pkg::CHAR_SPACE) stat_d = hrhp_pkg::STAT_DIGIT1;
			end
			hrhp_pkg::STAT_DIGIT1, hrhp_pkg::STAT_DIGIT2, hrhp_pkg::STAT_DIGIT3: begin
				if (is_digit) begin
					stat_acc_d = stat_mul[9:0];
					case (stat_q)
						hrhp_pkg::STAT_DIGIT1: stat_d = hrhp_pkg::STAT_DIGIT2;
						hrhp_pkg::STAT_DIGIT2: stat_d = hrhp_pkg::STAT_DIGIT3;
						default:               stat_d = hrhp_pkg::STAT_DONE;
					endcase
				end else begin
					stat_d = hrhp_pkg::STAT_DONE;
				end
			end
			default: begin
				stat_d = stat_q;
			end
		endcase

		// content length field match and digit run
		if (collecting_q) begin
			if (c == hrhp_pkg::CHAR_CR || c == hrhp_pkg::CHAR_LF) begin
				collecting_d = 1'b0;
			end else if (match_q != hrhp_pkg::CONV_ENDED) begin
				if (is_digit) begin
					len_acc_d = (len_mul[35:32] != 4'd0) ? '1 : len_mul[31:0];
				end else begin
					match_d = hrhp_pkg::CONV_ENDED;
				end
			end
		end else if (!len_done_q) begin
			if (match_q < hrhp_pkg::MATCH_FULL
					&& c == hrhp_pkg::LENGTH_PATTERN[match_q[3:0]]) begin
				match_d = match_q + 1'b1;
				if (match_d == hrhp_pkg::MATCH_FULL) begin
					len_done_d   = 1'b1;
					collecting_d = 1'b1;
				end
			end else begin
				match_d = (c == hrhp_pkg::LENGTH_PATTERN[0]) ? 5'd1 : 5'd0;
			end
		end
	end

	// result formed from the state after this byte
	always_comb begin
		result.body_offset     = hdr_done_d ? 12'(body_d) : 12'd0;
		result.header_complete = hdr_done_d;
		result.status_code     = (stat_d == hrhp_pkg::STAT_DONE) ? stat_acc_d : 10'd0;
		result.content_length  = len_done_d ? len_acc_d : 32'd0;
		result.length_found    = len_done_d;
	end

	// checks
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		stat_acc_q <= hrhp_pkg::STATUS_MAX)
		else $error("status accumulator beyond three digits");
	a_collect_done: assert property (@(posedge clk) disable iff (!arst_n)
		collecting_q |-> len_done_q)
		else $error("collecting length without a field match");
	a_term_idle: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_done_q |-> term_q == hrhp_pkg::TERM_NONE)
		else $error("terminator tracking active after header end");
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(step && beat.last_byte) |=> (offset_q == '0 && !hdr_done_q && !len_done_q))
		else $error("state not cleared after last byte");

endmodule

// File: src/hrhp_out_stage.sv
// result register towards the master side
module hrhp_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  hrhp_pkg::result_t result,
	output logic              free,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [55:0]       m_tdata
);

	logic              valid_q;
	hrhp_pkg::result_t res_q;

	// room for a new result when empty or being taken this cycle
	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata  = res_q;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= result;
		end
	end

endmodule

// File: src/http_response_header_parser.sv
// http response header parser: one byte per beat, one result beat per buffer
// result path: a last byte's result is formed from the input register and registered in the result register
// throughput: one byte per cycle; set by the single-byte state update between
// the input register and the result register; a last byte waits only while
// the result register is full and not being read
// reset: arst_n clears all parser state and both valid flags at once
module http_response_header_parser #(
	parameter int BUFFER_BYTES = 2048
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // rx_byte
	input  logic        s_tlast,   // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // body_offset, header_complete, status_code,
	                               // content_length, length_found
);

	logic              valid_s1;
	hrhp_pkg::beat_t   beat_s1;
	hrhp_pkg::result_t result;
	logic              out_free;
	logic              advance;

	// a held byte moves on unless it is a last byte facing a full result register
	assign advance = valid_s1 && (!beat_s1.last_byte || out_free);

	hrhp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	hrhp_parse_core #(
		.BUFFER_BYTES (BUFFER_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.beat   (beat_s1),
		.result (result)
	);

	hrhp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && beat_s1.last_byte),
		.result   (result),
		.free     (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
